// ===== src/nupb_pkg.sv =====
// nupb_pkg: shared types and constants for the nat udp port block table
// no dependencies
package nupb_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = IdxW + 1;

  localparam logic [15:0] PortBase = 16'd1024;

  typedef enum logic [2:0] {
    ACT_NEW    = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_ASSIGN = 3'd2,
    ACT_QUERY  = 3'd3,
    ACT_REV    = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    REG_SHARE_RATIO = 1'b0,
    REG_PORT_CHUNK  = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_SCAN_WAIT,
    S_MUL,
    S_HIDE,
    S_HIDE_WAIT,
    S_APPLY,
    S_OUT
  } state_e;

  // divider control: start a 32 by 16 restoring divide
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] quot;
    logic [15:0] rem;
  } div_rsp_t;

endpackage

// ===== src/nupb_div.sv =====
// nupb_div: shared serial restoring divider, one quotient bit per cycle
// depends on nupb_pkg
module nupb_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nupb_pkg::div_req_t req_i,
  output nupb_pkg::div_rsp_t rsp_o
);
  import nupb_pkg::*;

  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [31:0] quot_q, quot_d;
  logic [16:0] rem_q, rem_d;
  logic [15:0] dvs_q, dvs_d;
  logic [16:0] trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q[15:0], quot_q[31]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 6'd32;
      quot_d = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = trial - {1'b0, dvs_q};
        quot_d = {quot_q[30:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q[15:0];

  busy_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !req_i.start && cnt_q == 6'd1 |=> !busy_q)
    else $error("divider did not finish");
  start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q && cnt_q == 6'd32)
    else $error("divider did not start");
  rem_small: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && dvs_q != 16'd0 |-> rem_q < {1'b0, dvs_q})
    else $error("remainder out of range");
endmodule

// ===== src/nat_udp_port_block_table.sv =====
// nat_udp_port_block_table: top level, sequencer and entry memory
// depends on nupb_pkg and nupb_div
//
// Usage: one request word enters on in_valid_i/in_ready_o with action, keys and
// port; one result word leaves on out_valid_o/out_ready_i. An unused action or a
// reverse lookup below port 1024 goes straight to the output register. The other
// actions use a serial divide in the shared divider (new and reverse lookup, then
// taking the result), a scan of the 64-entry memory at one entry a cycle with
// registered read data, for delete, assign and query a re-read of the found entry,
// and for new and delete a second scan that hides entries of the same public
// address and slot. in_ready_o is high only while the sequencer is idle. A
// finished result sits in the output register until taken; the next word is
// accepted at the edge the result is taken.
// Reset clears valid and visibility flags (flip-flops), and the config
// registers to share ratio 1 and chunk 64512; no clearing pass is needed.
// Config writes are taken at any time through cfg_we_i.
module nat_udp_port_block_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  action_i,
  input  logic [31:0] private_ip_i,
  input  logic [31:0] private_index_i,
  input  logic [31:0] public_ip_i,
  input  logic [15:0] public_port_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] port_out_o,
  output logic [15:0] high_port_out_o,
  output logic [31:0] private_ip_out_o
);
  import nupb_pkg::*;

  logic [15:0] ratio_q, chunk_q;
  logic [15:0] eff_ratio, eff_chunk;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= 16'd1;
      chunk_q <= 16'd64512;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_SHARE_RATIO: ratio_q <= cfg_data_i;
        REG_PORT_CHUNK:  chunk_q <= cfg_data_i;
        default: ;
      endcase
    end
  end
  assign eff_ratio = (ratio_q == 16'd0) ? 16'd1 : ratio_q;
  assign eff_chunk = (chunk_q == 16'd0) ? 16'd1 : chunk_q;

  // entry memory, one read port with registered data, one write port
  logic [TableDepth-1:0] valid_q, vis_q;
  logic [31:0] mem_prv [TableDepth];
  logic [31:0] mem_pub [TableDepth];
  logic [15:0] mem_slot [TableDepth];
  logic [15:0] mem_low [TableDepth];
  logic [15:0] mem_next [TableDepth];
  logic [IdxW-1:0] rd_addr, wr_addr;
  logic            wr_en, wr_next_only;
  logic [31:0] rd_prv_q, rd_pub_q;
  logic [15:0] rd_slot_q, rd_low_q, rd_next_q;
  logic [31:0] wr_prv, wr_pub;
  logic [15:0] wr_slot, wr_low, wr_next;

  always_ff @(posedge clk_i) begin
    rd_prv_q  <= mem_prv[rd_addr];
    rd_pub_q  <= mem_pub[rd_addr];
    rd_slot_q <= mem_slot[rd_addr];
    rd_low_q  <= mem_low[rd_addr];
    rd_next_q <= mem_next[rd_addr];
    if (wr_en) begin
      mem_next[wr_addr] <= wr_next;
      if (!wr_next_only) begin
        mem_prv[wr_addr]  <= wr_prv;
        mem_pub[wr_addr]  <= wr_pub;
        mem_slot[wr_addr] <= wr_slot;
        mem_low[wr_addr]  <= wr_low;
      end
    end
  end

  div_req_t div_req;
  div_rsp_t div_rsp;
  nupb_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  state_e state_q, state_d;
  action_e act_q, act_d;
  logic [31:0] prv_q, prv_d, pub_q, pub_d, idx_q, idx_d;
  logic [15:0] port_q, port_d;
  logic [15:0] slot_q, slot_d, low_q, low_d;
  logic [CntW-1:0] ptr_q, ptr_d;   // issue pointer
  logic [IdxW-1:0] cmp_q, cmp_d;   // address of data now in the read register
  logic        cmp_v_q, cmp_v_d;
  logic        found_q, found_d, free_q, free_d;
  logic [IdxW-1:0] hit_q, hit_d, fre_q, fre_d;
  logic [31:0] hpub_q, hpub_d;     // key to hide
  logic [15:0] hslot_q, hslot_d;
  logic [TableDepth-1:0] valid_d, vis_d;
  logic        ov_q, ov_d;
  logic [1:0]  ost_q, ost_d;
  logic [15:0] op_q, op_d, oh_q, oh_d;
  logic [31:0] oip_q, oip_d;
  logic [31:0] prod;
  logic        rev_hit, prv_hit, hide_hit;
  logic        below_base;

  assign below_base = public_port_i < PortBase;
  assign prod = 32'(slot_q) * 32'(eff_chunk);
  assign prv_hit = cmp_v_q && valid_q[cmp_q] && rd_prv_q == prv_q;
  assign rev_hit = cmp_v_q && valid_q[cmp_q] && vis_q[cmp_q] && rd_pub_q == pub_q
                   && rd_slot_q == slot_q;
  assign hide_hit = cmp_v_q && valid_q[cmp_q] && rd_pub_q == hpub_q
                    && rd_slot_q == hslot_q;

  always_comb begin
    state_d = state_q;
    act_d = act_q; prv_d = prv_q; pub_d = pub_q; idx_d = idx_q; port_d = port_q;
    slot_d = slot_q; low_d = low_q; ptr_d = ptr_q; cmp_d = ptr_q[IdxW-1:0];
    cmp_v_d = 1'b0; found_d = found_q; free_d = free_q; hit_d = hit_q; fre_d = fre_q;
    hpub_d = hpub_q; hslot_d = hslot_q; valid_d = valid_q; vis_d = vis_q;
    ov_d = ov_q; ost_d = ost_q; op_d = op_q; oh_d = oh_q; oip_d = oip_q;
    div_req = '0;
    rd_addr = ptr_q[IdxW-1:0];
    wr_en = 1'b0; wr_next_only = 1'b0; wr_addr = hit_q;
    wr_prv = prv_q; wr_pub = pub_q; wr_slot = slot_q; wr_low = low_q; wr_next = low_q;
    in_ready_o = 1'b0;

    if (ov_q && out_ready_i) ov_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = !ov_q || out_ready_i;
        if (in_valid_i && in_ready_o) begin
          act_d = action_e'(action_i);
          prv_d = private_ip_i; pub_d = public_ip_i; idx_d = private_index_i;
          port_d = public_port_i;
          found_d = 1'b0; free_d = 1'b0; ptr_d = '0;
          ost_d = ST_OK; op_d = '0; oh_d = '0; oip_d = '0;
          priority if (action_i == ACT_NEW) begin
            div_req.start = 1'b1;
            div_req.dividend = private_index_i;
            div_req.divisor = eff_ratio;
            state_d = S_DIV;
          end else if (action_i == ACT_REV) begin
            if (below_base) begin
              ost_d = ST_NOTFOUND; state_d = S_OUT;
            end else begin
              div_req.start = 1'b1;
              div_req.dividend = {16'd0, public_port_i - PortBase};
              div_req.divisor = eff_chunk;
              state_d = S_DIV;
            end
          end else if (action_i == ACT_DELETE || action_i == ACT_ASSIGN
                       || action_i == ACT_QUERY) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_DIV: begin
        if (!div_rsp.busy) begin
          if (act_q == ACT_NEW) begin
            slot_d = div_rsp.rem;
          end else begin
            // quotient above 16 bits never matches a slot
            slot_d = div_rsp.quot[15:0];
            if (div_rsp.quot[31:16] != 16'd0) begin
              ost_d = ST_NOTFOUND; state_d = S_OUT;
            end
          end
          if (!(act_q == ACT_REV && div_rsp.quot[31:16] != 16'd0)) state_d = S_SCAN;
        end
      end
      S_SCAN, S_SCAN_WAIT: begin
        // compare the entry read last cycle, issue the next read
        if (prv_hit && !found_q && act_q != ACT_REV) begin
          found_d = 1'b1; hit_d = cmp_q;
        end
        if (act_q == ACT_NEW && cmp_v_q && !valid_q[cmp_q] && !free_q) begin
          free_d = 1'b1; fre_d = cmp_q;
        end
        if (act_q == ACT_REV && rev_hit && !found_q) begin
          found_d = 1'b1; oip_d = rd_prv_q;
        end
        if (state_q == S_SCAN) begin
          cmp_v_d = 1'b1;
          ptr_d = ptr_q + CntW'(1);
          if (ptr_q == CntW'(TableDepth - 1)) state_d = S_SCAN_WAIT;
        end else begin
          state_d = S_APPLY;
          if (act_q == ACT_NEW) state_d = S_MUL;
        end
      end
      S_MUL: begin
        low_d = PortBase + prod[15:0];
        if (!found_q) hit_d = fre_q;
        if (!found_q && !free_q) begin
          ost_d = ST_FULL; state_d = S_OUT;
        end else begin
          hpub_d = pub_q; hslot_d = slot_q; ptr_d = '0; state_d = S_HIDE;
        end
      end
      S_HIDE, S_HIDE_WAIT: begin
        if (hide_hit) vis_d[cmp_q] = 1'b0;
        if (state_q == S_HIDE) begin
          cmp_v_d = 1'b1;
          ptr_d = ptr_q + CntW'(1);
          if (ptr_q == CntW'(TableDepth - 1)) state_d = S_HIDE_WAIT;
        end else begin
          state_d = S_OUT;
          if (act_q == ACT_NEW) begin
            wr_en = 1'b1; wr_addr = hit_q;
            valid_d[hit_q] = 1'b1; vis_d[hit_q] = 1'b1;
            op_d = low_q; oh_d = low_q + eff_chunk - 16'd1;
          end else begin
            valid_d[hit_q] = 1'b0; vis_d[hit_q] = 1'b0;
          end
        end
      end
      S_APPLY: begin
        // issue the read of the found entry (address held at hit), act once it has returned
        rd_addr = hit_q;
        state_d = S_OUT;
        priority if (act_q == ACT_REV) begin
          if (!found_q) ost_d = ST_NOTFOUND;
        end else if (!found_q) begin
          ost_d = ST_NOTFOUND;
        end else if (!cmp_v_q) begin
          cmp_v_d = 1'b1; state_d = S_APPLY;
        end else if (act_q == ACT_DELETE) begin
          hpub_d = rd_pub_q; hslot_d = rd_slot_q; ptr_d = '0; state_d = S_HIDE;
        end else if (act_q == ACT_QUERY) begin
          op_d = rd_low_q; oh_d = rd_low_q + eff_chunk - 16'd1;
        end else begin
          op_d = rd_next_q;
          wr_en = 1'b1; wr_next_only = 1'b1;
          wr_next = (rd_next_q >= 16'(rd_low_q + eff_chunk - 16'd1)) ? rd_low_q
                    : rd_next_q + 16'd1;
        end
      end
      S_OUT: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      vis_q   <= '0;
      ov_q    <= 1'b0;
      cmp_v_q <= 1'b0;
      found_q <= 1'b0;
      free_q  <= 1'b0;
      act_q   <= ACT_NEW;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      vis_q   <= vis_d;
      ov_q    <= ov_d;
      cmp_v_q <= cmp_v_d;
      found_q <= found_d;
      free_q  <= free_d;
      act_q   <= act_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prv_q <= prv_d; pub_q <= pub_d; idx_q <= idx_d; port_q <= port_d;
    slot_q <= slot_d; low_q <= low_d; cmp_q <= cmp_d; hit_q <= hit_d; fre_q <= fre_d;
    hpub_q <= hpub_d; hslot_q <= hslot_d;
    ost_q <= ost_d; op_q <= op_d; oh_q <= oh_d; oip_q <= oip_d;
  end

  assign out_valid_o      = ov_q;
  assign status_o         = ost_q;
  assign port_out_o       = op_q;
  assign high_port_out_o  = oh_q;
  assign private_ip_out_o = oip_q;

  ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE)
    else $error("ready outside idle");
  vis_implies_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vis_q & ~valid_q) == '0)
    else $error("visible entry not valid");
  full_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MUL && !found_q && !free_q |=> $stable(valid_q))
    else $error("full table changed");
endmodule
